// File: hw/rtl/rgb_keyframe_interpolator_macros.svh
// Assertion macros shared by the RTL of the keyframe interpolator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RGB_KEYFRAME_INTERPOLATOR_MACROS_SVH
`define RGB_KEYFRAME_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RKI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rki_pkg.sv
package rki_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH);

  // Field widths.
  localparam int LVL_W      = 8;
  localparam int DUR_W      = 16;
  localparam int QUEUED_W   = 4;
  localparam int QUEUED_MAX = 15;

  // Bit-serial divider: one quotient bit per step.
  localparam int QUO_W      = LVL_W;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int PROD_W     = LVL_W + DUR_W;

  // Number of interpolated colour channels.
  localparam int NUM_CH     = 3;

  // Input operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] vibro;
    logic [DUR_W-1:0] dur;
  } keyframe_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// File: hw/rtl/rki_div_lane.sv
// One interpolation term: level times factor, divided by the divisor one
// quotient bit per step. The quotient always fits in QUO_W bits because the
// factor never exceeds the divisor.
module rki_div_lane (
  input  logic                          clk_i,
  input  rki_pkg::div_ctrl_t            ctrl_i,
  input  logic [rki_pkg::LVL_W-1:0]     level_i,
  input  logic [rki_pkg::DUR_W-1:0]     factor_i,
  input  logic [rki_pkg::DUR_W-1:0]     divisor_i,
  output logic [rki_pkg::QUO_W-1:0]     quo_o
);

  logic [rki_pkg::PROD_W-1:0]  prod;
  logic [rki_pkg::DUR_W:0]     trial;
  logic [rki_pkg::DUR_W:0]     diff;
  logic                        fits;

  logic [rki_pkg::DUR_W-1:0]   rem_q, rem_d;
  logic [rki_pkg::LVL_W-1:0]   low_q, low_d;
  logic [rki_pkg::QUO_W-1:0]   quo_q, quo_d;

  assign prod  = rki_pkg::PROD_W'(level_i) * rki_pkg::PROD_W'(factor_i);
  assign trial = {rem_q, low_q[rki_pkg::LVL_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    rem_d = rem_q;
    low_d = low_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = prod[rki_pkg::PROD_W-1:rki_pkg::LVL_W];
      low_d = prod[rki_pkg::LVL_W-1:0];
      quo_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = fits ? diff[rki_pkg::DUR_W-1:0] : trial[rki_pkg::DUR_W-1:0];
      low_d = {low_q[rki_pkg::LVL_W-2:0], 1'b0};
      quo_d = {quo_q[rki_pkg::QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// File: hw/rtl/rgb_keyframe_interpolator.sv
// RGB keyframe interpolator. Each word on the input channel is either a
// load, which appends a keyframe (red, green, blue, vibration and a duration
// in milliseconds) to a ring of RING_DEPTH slots, or a tick, which stands for
// one millisecond. Every input word yields exactly one output word carrying
// the shown levels, the number of keyframes still waiting (saturated at 15)
// and a flag set when a load found the ring full; the ring holds at most
// RING_DEPTH-1 waiting keyframes. A load goes from capture of the word
// straight to the update step. A tick passes through capture of the word,
// forming of the six products, the bit-serial division of those products
// by the duration in six parallel lanes, and the update of the state and
// the output register. The eight division steps set the tick rate.
// The keyframe store is cleared at reset through a valid bit per slot, so
// no clearing pass is needed and the block is ready straight after reset.
// The input channel takes a new word while an earlier result still waits
// in the output register; the block only holds off at its final update
// step until that register is free.
`include "rgb_keyframe_interpolator_macros.svh"

module rgb_keyframe_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [rki_pkg::LVL_W-1:0]      key_red_i,
  input  logic [rki_pkg::LVL_W-1:0]      key_green_i,
  input  logic [rki_pkg::LVL_W-1:0]      key_blue_i,
  input  logic [rki_pkg::LVL_W-1:0]      key_vibro_i,
  input  logic [rki_pkg::DUR_W-1:0]      key_duration_ms_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rki_pkg::LVL_W-1:0]      red_o,
  output logic [rki_pkg::LVL_W-1:0]      green_o,
  output logic [rki_pkg::LVL_W-1:0]      blue_o,
  output logic [rki_pkg::LVL_W-1:0]      vibro_o,
  output logic [rki_pkg::QUEUED_W-1:0]   queued_o,
  output logic                           load_refused_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  localparam int PEXT_W = rki_pkg::CNT_W + rki_pkg::QUEUED_W;

  logic [1:0]                      state_q, state_d;
  logic [rki_pkg::STEP_W-1:0]      step_q, step_d;

  // Captured input word.
  logic                            op_q;
  rki_pkg::keyframe_t              key_q;

  // Ring bookkeeping.
  logic [rki_pkg::SLOT_W-1:0]      load_q, play_q;
  logic [rki_pkg::CNT_W-1:0]       pend_q;
  logic [rki_pkg::DUR_W-1:0]       el_q;
  logic [rki_pkg::LVL_W-1:0]       shown_r_q, shown_g_q, shown_b_q, shown_v_q;

  // Keyframe store with a valid bit per slot; an unwritten slot reads as zero.
  rki_pkg::keyframe_t              mem_q [rki_pkg::RING_DEPTH];
  logic [rki_pkg::RING_DEPTH-1:0]  kf_valid_q;
  rki_pkg::keyframe_t              rd_nx_q, rd_cu_q;
  logic [rki_pkg::SLOT_W-1:0]      prev_slot;

  // Output register.
  logic                            out_valid_q;
  logic [rki_pkg::LVL_W-1:0]       out_r_q, out_g_q, out_b_q, out_v_q;
  logic [rki_pkg::QUEUED_W-1:0]    out_queued_q;
  logic                            out_refused_q;

  // Datapath.
  logic [rki_pkg::DUR_W-1:0]       el_inc, dur_p, e_ms, pe_ms;
  logic                            take, refused, commit, accept;
  rki_pkg::div_ctrl_t              div_ctrl;
  logic [rki_pkg::LVL_W-1:0]       cur_lvl [rki_pkg::NUM_CH];
  logic [rki_pkg::LVL_W-1:0]       nx_lvl  [rki_pkg::NUM_CH];
  logic [rki_pkg::QUO_W-1:0]       quo_from [rki_pkg::NUM_CH];
  logic [rki_pkg::QUO_W-1:0]       quo_to   [rki_pkg::NUM_CH];
  logic [rki_pkg::LVL_W-1:0]       blend [rki_pkg::NUM_CH];
  logic [rki_pkg::CNT_W-1:0]       pend_d;
  logic [PEXT_W-1:0]               pend_ext;
  logic [rki_pkg::QUEUED_W-1:0]    queued_d;
  logic [rki_pkg::SLOT_W:0]        fill_sum;
  logic [rki_pkg::SLOT_W-1:0]      fill_slot;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign commit     = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);

  assign prev_slot = (play_q == '0) ? rki_pkg::SLOT_W'(rki_pkg::RING_DEPTH - 1)
                                    : play_q - 1'b1;

  // The elapsed counter saturates rather than wrapping.
  assign el_inc = (el_q == '1) ? el_q : el_q + 1'b1;
  assign dur_p  = rd_nx_q.dur;
  assign e_ms   = (el_inc > dur_p) ? dur_p : el_inc;
  assign pe_ms  = dur_p - e_ms;
  assign take   = (pend_q != '0) && (dur_p <= el_inc);
  assign refused = (pend_q >= rki_pkg::CNT_W'(rki_pkg::RING_DEPTH - 1));

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_i == rki_pkg::OP_LOAD) ? ST_WB : ST_CALC;
        end
      end
      ST_CALC: begin
        div_ctrl.load = 1'b1;
        step_d        = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        step_d        = step_q + 1'b1;
        if (step_q == rki_pkg::STEP_W'(rki_pkg::QUO_W - 1)) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      key_q.red   <= key_red_i;
      key_q.green <= key_green_i;
      key_q.blue  <= key_blue_i;
      key_q.vibro <= key_vibro_i;
      key_q.dur   <= key_duration_ms_i;
    end
  end

  // Keyframe store: written at the load slot, read at the next and the
  // previous slot every cycle. The slots only move at a commit, so the data
  // read at acceptance is settled by the time the products are formed.
  always_ff @(posedge clk_i) begin
    if (commit && (op_q == rki_pkg::OP_LOAD) && !refused) begin
      mem_q[load_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_nx_q <= kf_valid_q[play_q]    ? mem_q[play_q]    : '0;
    rd_cu_q <= kf_valid_q[prev_slot] ? mem_q[prev_slot] : '0;
  end

  // Six division lanes: the outgoing and incoming term of each colour.
  assign cur_lvl[0] = rd_cu_q.red;
  assign cur_lvl[1] = rd_cu_q.green;
  assign cur_lvl[2] = rd_cu_q.blue;
  assign nx_lvl[0]  = rd_nx_q.red;
  assign nx_lvl[1]  = rd_nx_q.green;
  assign nx_lvl[2]  = rd_nx_q.blue;

  for (genvar ch = 0; ch < rki_pkg::NUM_CH; ch++) begin : g_ch
    rki_div_lane u_from (
      .clk_i     (clk_i),
      .ctrl_i    (div_ctrl),
      .level_i   (cur_lvl[ch]),
      .factor_i  (pe_ms),
      .divisor_i (dur_p),
      .quo_o     (quo_from[ch])
    );

    rki_div_lane u_to (
      .clk_i     (clk_i),
      .ctrl_i    (div_ctrl),
      .level_i   (nx_lvl[ch]),
      .factor_i  (e_ms),
      .divisor_i (dur_p),
      .quo_o     (quo_to[ch])
    );

    // The two truncated terms are added and wrap to eight bits.
    assign blend[ch] = quo_from[ch] + quo_to[ch];
  end

  // Pending count after this word, and the saturated copy shown to the user.
  always_comb begin
    pend_d = pend_q;
    if (op_q == rki_pkg::OP_LOAD) begin
      if (!refused) begin
        pend_d = pend_q + 1'b1;
      end
    end else if (take) begin
      pend_d = pend_q - 1'b1;
    end
  end

  assign pend_ext = PEXT_W'(pend_d);
  assign queued_d = (pend_ext > PEXT_W'(rki_pkg::QUEUED_MAX)) ? '1
                                                            : pend_ext[rki_pkg::QUEUED_W-1:0];

  // State update at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q     <= '0;
      play_q     <= '0;
      pend_q     <= '0;
      el_q       <= '0;
      shown_r_q  <= '0;
      shown_g_q  <= '0;
      shown_b_q  <= '0;
      shown_v_q  <= '0;
      kf_valid_q <= '0;
    end else if (commit) begin
      pend_q <= pend_d;
      if (op_q == rki_pkg::OP_LOAD) begin
        if (!refused) begin
          kf_valid_q[load_q] <= 1'b1;
          load_q <= (load_q == rki_pkg::SLOT_W'(rki_pkg::RING_DEPTH - 1)) ? '0
                                                                        : load_q + 1'b1;
        end
      end else if (take) begin
        // The next keyframe has been reached: show it whole and move on.
        shown_r_q <= rd_nx_q.red;
        shown_g_q <= rd_nx_q.green;
        shown_b_q <= rd_nx_q.blue;
        shown_v_q <= rd_nx_q.vibro;
        play_q    <= (play_q == rki_pkg::SLOT_W'(rki_pkg::RING_DEPTH - 1)) ? '0
                                                                         : play_q + 1'b1;
        el_q      <= '0;
      end else begin
        el_q <= el_inc;
        if ((pend_q != '0) && (dur_p != '0)) begin
          shown_r_q <= blend[0];
          shown_g_q <= blend[1];
          shown_b_q <= blend[2];
        end
      end
    end
  end

  // Output register. A load shows the levels from before the word, which
  // the shown registers still hold at the commit edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_queued_q  <= queued_d;
      out_refused_q <= (op_q == rki_pkg::OP_LOAD) && refused;
      if ((op_q == rki_pkg::OP_TICK) && take) begin
        out_r_q <= rd_nx_q.red;
        out_g_q <= rd_nx_q.green;
        out_b_q <= rd_nx_q.blue;
        out_v_q <= rd_nx_q.vibro;
      end else if ((op_q == rki_pkg::OP_TICK) && (pend_q != '0) && (dur_p != '0)) begin
        out_r_q <= blend[0];
        out_g_q <= blend[1];
        out_b_q <= blend[2];
        out_v_q <= shown_v_q;
      end else begin
        out_r_q <= shown_r_q;
        out_g_q <= shown_g_q;
        out_b_q <= shown_b_q;
        out_v_q <= shown_v_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = out_r_q;
  assign green_o        = out_g_q;
  assign blue_o         = out_b_q;
  assign vibro_o        = out_v_q;
  assign queued_o       = out_queued_q;
  assign load_refused_o = out_refused_q;

  // The load slot always sits pending_count slots after the play slot.
  assign fill_sum  = {1'b0, play_q} + (rki_pkg::SLOT_W + 1)'(pend_q);
  assign fill_slot = (fill_sum >= (rki_pkg::SLOT_W + 1)'(rki_pkg::RING_DEPTH))
                   ? rki_pkg::SLOT_W'(fill_sum - (rki_pkg::SLOT_W + 1)'(rki_pkg::RING_DEPTH))
                   : fill_sum[rki_pkg::SLOT_W-1:0];

  `RKI_ASSERT_SAME(a_ring_consistent, 1'b1, fill_slot == load_q, "ring pointers disagree with count")
  `RKI_ASSERT_SAME(a_refused_full, out_valid_q && out_refused_q, pend_q == rki_pkg::CNT_W'(rki_pkg::RING_DEPTH - 1), "refusal shown while ring not full")
  `RKI_ASSERT_NEXT(a_tick_divides, accept && (op_i == rki_pkg::OP_TICK), state_q == ST_CALC, "tick skipped the division")
  `RKI_ASSERT_SAME(a_wb_waits, (state_q == ST_WB) && out_valid_q && out_stall_i, !commit, "result overwritten while stalled")

endmodule
